// ===== hdl/alsl_pkg.sv =====
// Shared types, codes and constants of the adaptive share limiter.
package alsl_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_IMPORT    = 2'd0;
    localparam logic [1:0] OP_ROUND_END = 2'd1;
    localparam logic [1:0] OP_RESTART   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_LITERALS_PER_ROUND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_BEFORE_RAISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_THRESHOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_THRESHOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCER_COUNT      = 3'd5;

    // Register reset values
    localparam logic [19:0] LITERALS_RESET = 20'd1500;
    localparam logic [7:0]  LIMIT_RESET    = 8'd2;
    localparam logic [15:0] RAISE_RESET    = 16'd1;
    localparam logic [15:0] UNDER_RESET    = 16'd75;
    localparam logic [15:0] OVER_RESET     = 16'd98;
    localparam logic [3:0]  COUNT_RESET    = 4'd8;

    // Limit and usage bounds
    localparam logic [7:0]  LIMIT_MAX   = 8'd255;
    localparam logic [7:0]  LIMIT_FLOOR = 8'd2;
    localparam logic [15:0] USAGE_MAX   = 16'hFFFF;
    localparam int unsigned RESULT_CAP  = 8;

    // Divider widths
    localparam int unsigned DEN_W  = 20;
    localparam int unsigned QUOT_W = 16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  producer_index;
        logic [7:0]  clause_quality;
        logic [15:0] clause_size;
    } t_in_req;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  which_producer;
        logic [7:0]  limit_now;
        logic [15:0] usage_percent;
        logic        last;
    } t_out_res;

    typedef struct packed {
        logic [19:0] literals_per_round;
        logic [7:0]  initial_limit;
        logic [15:0] rounds_before_raise;
        logic [15:0] under_threshold;
        logic [15:0] over_threshold;
        logic [3:0]  producer_count;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic walk_clear;
        logic import_do;
        logic restart_do;
        logic div_start;
        logic walk_emit;
        logic round_done;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_done;
        logic walk_last;
    } t_sts;

endpackage

// ===== hdl/adaptive_lbd_share_limiter_core.sv =====
// Top level of the adaptive quality-limit clause-sharing limiter.
// Import request: the result register loads once the output is free; new requests wait until then.
// Round-end request: per producer in use, the bit-serial usage divider runs (cut short
// when usage saturates), then the result waits for a free output; results in producer order.
// Restart request: no result. Configuration writes take effect next cycle.
// Synchronous active-low reset: limits to 2, counters and round to zero, registers to defaults.
module adaptive_lbd_share_limiter_core #(
    parameter int unsigned MAX_PRODUCERS = 8,
    parameter int unsigned COUNTER_BITS  = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  alsl_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output alsl_pkg::t_out_res                 o_out_res,
    input  logic                               i_cfg_we,
    input  logic [alsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [alsl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import alsl_pkg::*;

    // Only the first eight producers can ever be in use: hold at most that many entries
    localparam int unsigned TABLE_DEPTH =
        (MAX_PRODUCERS < RESULT_CAP) ? MAX_PRODUCERS : RESULT_CAP;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.literals_per_round  <= LITERALS_RESET;
            r_cfg.initial_limit       <= LIMIT_RESET;
            r_cfg.rounds_before_raise <= RAISE_RESET;
            r_cfg.under_threshold     <= UNDER_RESET;
            r_cfg.over_threshold      <= OVER_RESET;
            r_cfg.producer_count      <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LITERALS_PER_ROUND:  r_cfg.literals_per_round  <= i_cfg_data;
                CFG_INITIAL_LIMIT:       r_cfg.initial_limit       <= i_cfg_data[7:0];
                CFG_ROUNDS_BEFORE_RAISE: r_cfg.rounds_before_raise <= i_cfg_data[15:0];
                CFG_UNDER_THRESHOLD:     r_cfg.under_threshold     <= i_cfg_data[15:0];
                CFG_OVER_THRESHOLD:      r_cfg.over_threshold      <= i_cfg_data[15:0];
                CFG_PRODUCER_COUNT:      r_cfg.producer_count      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Controller: takes one request at a time and sequences the datapath
    alsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_req.operation),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: tables, usage divider and the result register that decouples
    // the output side, so a new request is taken while a result still waits
    alsl_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

// ===== hdl/alsl_div.sv =====
// Iterative usage divider: 100 * count / divisor, one quotient bit per cycle.
module alsl_div #(
    parameter int unsigned COUNTER_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [COUNTER_BITS-1:0]           i_count,
    input  logic [alsl_pkg::DEN_W-1:0]        i_den,
    output logic                              o_done,
    output logic [alsl_pkg::QUOT_W-1:0]       o_quot,
    output logic                              o_big
);
    import alsl_pkg::*;

    localparam int unsigned NUM_W  = COUNTER_BITS + 7;
    localparam int unsigned HI_W   = NUM_W - QUOT_W;
    localparam int unsigned CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int unsigned STEP_W = $clog2(QUOT_W);

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_CHECK,
        DS_STEP
    } t_state;

    t_state              r_state;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [QUOT_W-1:0]   r_quot;
    logic [STEP_W-1:0]   r_step;
    logic                r_big;
    logic                r_done;

    logic [NUM_W-1:0]    count_ext;
    logic [NUM_W-1:0]    scaled;
    logic [CMP_W-1:0]    num_hi;
    logic [CMP_W-1:0]    den_ext;
    logic [DEN_W:0]      shifted;
    logic                fits;

    // 100 * count as shifts and adds
    assign count_ext = NUM_W'(i_count);
    assign scaled    = (count_ext << 6) + (count_ext << 5) + (count_ext << 2);

    // Quotient above 16 bits when the upper part already reaches the divisor
    assign num_hi  = CMP_W'(r_num[NUM_W-1:QUOT_W]);
    assign den_ext = CMP_W'(r_den);

    assign shifted = {r_rem, r_quot[QUOT_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_done  <= 1'b0;
            r_big   <= 1'b0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                DS_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_state <= DS_CHECK;
                    end
                end
                DS_CHECK: begin
                    r_step <= '0;
                    if (num_hi >= den_ext) begin
                        r_big   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= DS_IDLE;
                    end else begin
                        r_big   <= 1'b0;
                        r_done  <= 1'b0;
                        r_state <= DS_STEP;
                    end
                end
                DS_STEP: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(QUOT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= DS_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= DS_IDLE;
                end
            endcase
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (r_state == DS_IDLE && i_start) begin
            r_num <= scaled;
            r_den <= i_den;
        end
        if (r_state == DS_CHECK) begin
            r_rem  <= DEN_W'(num_hi);
            r_quot <= r_num[QUOT_W-1:0];
        end
        if (r_state == DS_STEP) begin
            r_rem  <= fits ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_big  = r_big;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == DS_STEP |-> r_rem < r_den)
        else $error("partial remainder reached the divisor");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == DS_CHECK |-> $past(i_start))
        else $error("divider left idle without a start");

endmodule

// ===== hdl/alsl_ctrl.sv =====
// Sequencing controller: request decode, import issue and round-end walk.
module alsl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_op,
    output logic            o_in_stall,
    input  alsl_pkg::t_sts  i_sts,
    output alsl_pkg::t_cmd  o_cmd
);
    import alsl_pkg::*;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_IMPORT,
        CS_RESTART,
        CS_ROUND_START,
        CS_ROUND_WAIT,
        CS_ROUND_EMIT
    } t_state;

    t_state r_state;
    logic   take;

    assign o_in_stall = !i_rst_n || (r_state != CS_IDLE);
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            unique case (r_state)
                CS_IDLE: begin
                    if (take) begin
                        unique case (i_in_op)
                            OP_IMPORT:    r_state <= CS_IMPORT;
                            OP_ROUND_END: r_state <= CS_ROUND_START;
                            OP_RESTART:   r_state <= CS_RESTART;
                            default:      r_state <= CS_IDLE;
                        endcase
                    end
                end
                CS_IMPORT: begin
                    if (i_sts.out_free) begin
                        r_state <= CS_IDLE;
                    end
                end
                CS_RESTART: begin
                    r_state <= CS_IDLE;
                end
                CS_ROUND_START: begin
                    r_state <= CS_ROUND_WAIT;
                end
                CS_ROUND_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= CS_ROUND_EMIT;
                    end
                end
                CS_ROUND_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= i_sts.walk_last ? CS_IDLE : CS_ROUND_START;
                    end
                end
                default: begin
                    r_state <= CS_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = take;
        o_cmd.walk_clear = take && (i_in_op == OP_ROUND_END);
        o_cmd.import_do  = (r_state == CS_IMPORT) && i_sts.out_free;
        o_cmd.restart_do = (r_state == CS_RESTART);
        o_cmd.div_start  = (r_state == CS_ROUND_START);
        o_cmd.walk_emit  = (r_state == CS_ROUND_EMIT) && i_sts.out_free;
        o_cmd.round_done = o_cmd.walk_emit && i_sts.walk_last;
    end

endmodule

// ===== hdl/alsl_dp.sv =====
// Datapath: limit table, literal counters, round counter, divider and result register.
module alsl_dp #(
    parameter int unsigned TABLE_DEPTH  = 8,
    parameter int unsigned COUNTER_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alsl_pkg::t_cfg      i_cfg,
    input  alsl_pkg::t_in_req   i_in_req,
    input  alsl_pkg::t_cmd      i_cmd,
    output alsl_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output alsl_pkg::t_out_res  o_out_res
);
    import alsl_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0]              r_limit [TABLE_DEPTH];
    logic [COUNTER_BITS-1:0] r_cnt   [TABLE_DEPTH];
    logic [31:0]             r_round;
    logic [IDX_W-1:0]        r_walk;
    t_in_req                 r_req;
    logic                    r_out_valid;
    t_out_res                r_out;

    logic [3:0]              num_active;
    logic                    in_use;
    logic [IDX_W-1:0]        imp_idx;
    logic [7:0]              imp_lim;
    logic                    imp_pass;
    logic [COUNTER_BITS:0]   sum;
    logic [COUNTER_BITS-1:0] sat_sum;

    logic [DEN_W-1:0]        den;
    logic                    div_done;
    logic [QUOT_W-1:0]       quot;
    logic                    big;
    logic [7:0]              walk_lim;
    logic [7:0]              new_lim;
    logic                    raise_ok;
    logic                    below;
    logic                    above;
    logic                    walk_last;
    logic                    out_free;

    // Producers in use: zero counts as one, capped by the table
    assign num_active = (i_cfg.producer_count == 4'd0) ? 4'd1 :
                        (i_cfg.producer_count > 4'(TABLE_DEPTH)) ? 4'(TABLE_DEPTH) :
                        i_cfg.producer_count;

    // Import path
    assign in_use   = {1'b0, r_req.producer_index} < num_active;
    assign imp_idx  = IDX_W'(r_req.producer_index);
    assign imp_lim  = in_use ? r_limit[imp_idx] : 8'd0;
    assign imp_pass = in_use && (r_req.clause_quality <= imp_lim);
    assign sum      = {1'b0, r_cnt[imp_idx]} + (COUNTER_BITS + 1)'(r_req.clause_size);
    assign sat_sum  = sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];

    // Round-end path
    assign den = (i_cfg.literals_per_round == '0) ? DEN_W'(1) : i_cfg.literals_per_round;

    alsl_div #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_count (r_cnt[r_walk]),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_big   (big)
    );

    assign walk_lim  = r_limit[r_walk];
    assign raise_ok  = {16'd0, i_cfg.rounds_before_raise} < r_round;
    assign below     = !big && (quot < i_cfg.under_threshold);
    assign above     = big || (quot > i_cfg.over_threshold);
    assign walk_last = (4'(r_walk) + 4'd1) == num_active;

    always_comb begin
        new_lim = walk_lim;
        priority if (raise_ok && below) begin
            if (walk_lim != LIMIT_MAX) begin
                new_lim = walk_lim + 8'd1;
            end
        end else if (above) begin
            if (walk_lim > LIMIT_FLOOR) begin
                new_lim = walk_lim - 8'd1;
            end
        end else begin
            new_lim = walk_lim;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_limit[i] <= LIMIT_RESET;
                r_cnt[i]   <= '0;
            end
            r_round     <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.import_do || i_cmd.walk_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.walk_clear) begin
                r_walk <= '0;
            end
            if (i_cmd.import_do && imp_pass) begin
                r_cnt[imp_idx] <= sat_sum;
            end
            if (i_cmd.walk_emit) begin
                r_limit[r_walk] <= new_lim;
                if (!walk_last) begin
                    r_walk <= r_walk + IDX_W'(1);
                end
            end
            if (i_cmd.round_done) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    r_cnt[i] <= '0;
                end
                if (r_round != '1) begin
                    r_round <= r_round + 32'd1;
                end
            end
            if (i_cmd.restart_do) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    r_limit[i] <= i_cfg.initial_limit;
                    r_cnt[i]   <= '0;
                end
                r_round <= '0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_req;
        end
        if (i_cmd.import_do) begin
            r_out.accepted       <= imp_pass;
            r_out.which_producer <= r_req.producer_index;
            r_out.limit_now      <= imp_lim;
            r_out.usage_percent  <= '0;
            r_out.last           <= 1'b1;
        end else if (i_cmd.walk_emit) begin
            r_out.accepted       <= 1'b0;
            r_out.which_producer <= 3'(r_walk);
            r_out.limit_now      <= new_lim;
            r_out.usage_percent  <= big ? USAGE_MAX : quot;
            r_out.last           <= walk_last;
        end
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.div_done  = div_done;
    assign o_sts.walk_last = walk_last;
    assign o_out_valid     = r_out_valid;
    assign o_out_res       = r_out;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.import_do || i_cmd.walk_emit) |-> out_free)
        else $error("result register overwritten while held");

    a_walk_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_emit && !walk_last) |=> r_walk == $past(r_walk) + IDX_W'(1))
        else $error("producer walk did not advance");

    a_round_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round_done |=> r_cnt[0] == '0)
        else $error("literal counter not cleared at round end");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.import_do && i_cmd.walk_emit))
        else $error("import and round-end result loaded together");

endmodule
